// ===== rtl/hdc_pkg.sv =====
// ----------------------------------------------------------------------------
// hdc_pkg
// Shared types and constants of the hot-plug-detect classifier.
// ----------------------------------------------------------------------------
package hdc_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned CfgIdxWidth       = 2;
  localparam int unsigned CfgDataWidth      = 16;

  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DETECT_ENABLE = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_IRQ_MIN       = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_LEVEL_MIN     = cfg_idx_t'(2);

  localparam logic [CfgDataWidth-1:0] IrqMinReset   = 16'd250;
  localparam logic [CfgDataWidth-1:0] LevelMinReset = 16'd2000;

  typedef enum logic [1:0] {
    EVT_IRQ  = 2'd0,
    EVT_HIGH = 2'd1,
    EVT_LOW  = 2'd2
  } hpd_event_e;

  typedef struct packed {
    logic                    detect_enable;
    logic [CfgDataWidth-1:0] irq_min_ticks;
    logic [CfgDataWidth-1:0] level_min_ticks;
  } cfg_t;

  // single-bit classifier state
  typedef struct packed {
    logic raw_last;
    logic accepted_level;
    logic confirm_pending;
  } flags_t;

  typedef struct packed {
    logic       valid;
    hpd_event_e code;
  } result_t;

endpackage

// ===== rtl/hdc_cfg.sv =====
// ----------------------------------------------------------------------------
// hdc_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module hdc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  hdc_pkg::cfg_idx_t                cfg_index_i,
  input  logic [hdc_pkg::CfgDataWidth-1:0] cfg_data_i,
  output hdc_pkg::cfg_t                    cfg_o
);
  import hdc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DETECT_ENABLE: cfg_d.detect_enable   = cfg_data_i[0];
        CFG_IRQ_MIN:       cfg_d.irq_min_ticks   = cfg_data_i;
        CFG_LEVEL_MIN:     cfg_d.level_min_ticks = cfg_data_i;
        default:           cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_enable   <= 1'b0;
      cfg_q.irq_min_ticks   <= IrqMinReset;
      cfg_q.level_min_ticks <= LevelMinReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hdc_core.sv =====
// ----------------------------------------------------------------------------
// hdc_core
// Next-state and event logic for one sample tick.
// ----------------------------------------------------------------------------
module hdc_core #(
  parameter int unsigned CountWidth = hdc_pkg::CountWidthDefault
) (
  input  hdc_pkg::cfg_t          cfg_i,
  input  logic                   hpd_sample_i,
  input  logic                   dp_mode_i,
  input  logic                   restart_i,
  input  hdc_pkg::flags_t        flags_i,
  input  logic [CountWidth-1:0]  ticks_i,
  input  logic [CountWidth-1:0]  timer_i,
  output hdc_pkg::flags_t        flags_o,
  output logic [CountWidth-1:0]  ticks_o,
  output logic [CountWidth-1:0]  timer_o,
  output hdc_pkg::result_t       result_o
);
  import hdc_pkg::*;

  // compare width covers both the counter and the 16-bit registers
  localparam int unsigned CmpWidth =
    (CountWidth > CfgDataWidth) ? CountWidth : CfgDataWidth;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  logic [CountWidth-1:0] ticks_inc;
  logic [CountWidth-1:0] timer_dec;
  logic [CountWidth-1:0] level_load;
  logic [CmpWidth-1:0]   delta_ext, irq_ext, level_ext, max_ext;
  logic                  edge_det, spaced, short_gap, is_irq;

  always_comb begin
    ticks_inc = (ticks_i == CountMax) ? ticks_i : ticks_i + 1'b1;
    timer_dec = (flags_i.confirm_pending && (timer_i != '0)) ? timer_i - 1'b1 : timer_i;

    delta_ext  = CmpWidth'(ticks_inc);
    irq_ext    = CmpWidth'(cfg_i.irq_min_ticks);
    level_ext  = CmpWidth'(cfg_i.level_min_ticks);
    max_ext    = CmpWidth'(CountMax);
    level_load = (level_ext > max_ext) ? CountMax : level_ext[CountWidth-1:0];

    spaced    = (delta_ext >= irq_ext);
    short_gap = (delta_ext < level_ext);
    edge_det  = !restart_i && cfg_i.detect_enable && (hpd_sample_i != flags_i.raw_last);
    is_irq    = !flags_i.accepted_level && hpd_sample_i && short_gap;

    flags_o         = flags_i;
    flags_o.raw_last = hpd_sample_i;
    ticks_o         = ticks_inc;
    timer_o         = timer_dec;
    result_o.valid  = 1'b0;
    result_o.code   = EVT_IRQ;

    if (restart_i) begin
      flags_o.accepted_level = hpd_sample_i;
      ticks_o                = '0;
    end else if (edge_det) begin
      ticks_o                 = '0;
      flags_o.confirm_pending = 1'b0;
      timer_o                 = '0;
      if (spaced) begin
        if (is_irq) begin
          result_o.valid = dp_mode_i;
          result_o.code  = EVT_IRQ;
        end else if (!short_gap) begin
          flags_o.confirm_pending = 1'b1;
          timer_o                 = level_load;
        end
        flags_o.accepted_level = hpd_sample_i;
      end
    end

    // confirm expiry, after the edge has been evaluated
    if (flags_o.confirm_pending && (timer_o == '0)) begin
      flags_o.confirm_pending = 1'b0;
      if ((hpd_sample_i == flags_o.accepted_level) && dp_mode_i && !result_o.valid) begin
        result_o.valid = 1'b1;
        result_o.code  = hpd_sample_i ? EVT_HIGH : EVT_LOW;
      end
    end
  end

endmodule

// ===== rtl/hotplug_detect_classifier.sv =====
// ----------------------------------------------------------------------------
// hotplug_detect_classifier
// Debounces and classifies a sampled hot-plug-detect pin into IRQ pulse,
// attach and detach events.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register until the output
//   slot is free, then is evaluated; its event, if any, is registered.
// Throughput: one item per cycle; the input and output registers stall
//   only when a waiting event is not taken.
// Reset: asynchronous, active low; state clears to zero, registers load
//   detect off, IRQ spacing 250 and level spacing 2000.
// ----------------------------------------------------------------------------
module hotplug_detect_classifier #(
  parameter int unsigned COUNT_WIDTH = hdc_pkg::CountWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             hpd_sample_i,
  input  logic                             dp_mode_i,
  input  logic                             restart_i,
  // event channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       hpd_event_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  hdc_pkg::cfg_idx_t                cfg_index_i,
  input  logic [hdc_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import hdc_pkg::*;

  cfg_t cfg;

  // input register
  logic s1_valid_q, s1_valid_d;
  logic s1_hpd_q, s1_dp_q, s1_restart_q;

  // classifier state
  flags_t                 flags_q, flags_d;
  logic [COUNT_WIDTH-1:0] ticks_q, ticks_d;
  logic [COUNT_WIDTH-1:0] timer_q, timer_d;

  // result register
  logic       out_valid_q, out_valid_d;
  hpd_event_e event_q;
  result_t    result;

  logic out_free, s1_advance, in_fire;

  hdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hdc_core #(
    .CountWidth (COUNT_WIDTH)
  ) u_core (
    .cfg_i        (cfg),
    .hpd_sample_i (s1_hpd_q),
    .dp_mode_i    (s1_dp_q),
    .restart_i    (s1_restart_q),
    .flags_i      (flags_q),
    .ticks_i      (ticks_q),
    .timer_i      (timer_q),
    .flags_o      (flags_d),
    .ticks_o      (ticks_d),
    .timer_o      (timer_d),
    .result_o     (result)
  );

  // The output slot is free when empty or being drained this cycle; the
  // staged item moves on then, and a new item can enter behind it.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // A tick with no event still advances the state but leaves the slot empty.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_advance) begin
      out_valid_d = result.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      ticks_q     <= '0;
      timer_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_advance) begin
        flags_q <= flags_d;
        ticks_q <= ticks_d;
        timer_q <= timer_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_hpd_q     <= hpd_sample_i;
      s1_dp_q      <= dp_mode_i;
      s1_restart_q <= restart_i;
    end
    if (s1_advance && result.valid) begin
      event_q <= result.code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hpd_event_o = event_q;

  // A running confirm timer always belongs to a pending confirm.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timer_q != '0) |-> flags_q.confirm_pending)
    else $error("confirm timer running without a pending confirm");

  // Events carry only the three defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hpd_event_o == EVT_IRQ || hpd_event_o == EVT_HIGH ||
                     hpd_event_o == EVT_LOW))
    else $error("undefined event code");

  // A staged item blocked by a full output slot stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_hpd_q) &&
                                   $stable(s1_restart_q)))
    else $error("staged item lost while stalled");

  // State moves only when a staged item is evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_advance |=> ($stable(ticks_q) && $stable(timer_q) && $stable(flags_q)))
    else $error("state changed without an item");

endmodule

// ===== dv/tb_hotplug_detect_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_hotplug_detect_classifier
// Self-checking bench for the hot-plug-detect classifier. A scoreboard class
// predicts the event of every accepted pin item and compares it with the
// events taken from the output channel. The pin is shaped into pulse trains
// sized against the current spacing registers, under random stalls.
// ----------------------------------------------------------------------------
module tb_hotplug_detect_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import hdc_pkg::*;

  localparam int unsigned CountWidth    = CountWidthDefault;
  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned SettleCycles  = 4;     // item in flight plus output register
  localparam int unsigned DrainLimit    = 2000;
  localparam int unsigned TimeoutCycles = 2_000_000;
  localparam int unsigned IdlePercent   = 37;

  // --------------------------------------------------------------------------
  // Event predictor and expected-event store
  // --------------------------------------------------------------------------
  class hpd_scoreboard;
    logic                    detect_en;
    logic [CfgDataWidth-1:0] irq_min;
    logic [CfgDataWidth-1:0] level_min;
    logic                    raw_last;
    logic                    accepted_level;
    logic                    confirm_pending;
    logic [CountWidth-1:0]   since_edge;
    logic [CountWidth-1:0]   confirm_timer;
    hpd_event_e              event_q[$];
    int unsigned             errors;

    function new();
      errors = 0;
      load_reset();
    endfunction

    function void load_reset();
      detect_en       = 1'b0;
      irq_min         = IrqMinReset;
      level_min       = LevelMinReset;
      raw_last        = 1'b0;
      accepted_level  = 1'b0;
      confirm_pending = 1'b0;
      since_edge      = '0;
      confirm_timer   = '0;
      event_q.delete();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_DETECT_ENABLE: detect_en = data[0];
        CFG_IRQ_MIN:       irq_min   = data;
        CFG_LEVEL_MIN:     level_min = data;
        default: ;
      endcase
    endfunction

    // One pin tick: timer, then edge, then confirm expiry.
    function void note_input(logic pin, logic dp, logic restart);
      logic                  fired;
      logic                  toggled;
      logic [CountWidth-1:0] spacing;
      logic [CountWidth-1:0] cmax;
      hpd_event_e            code;
      cmax  = '1;
      fired = 1'b0;
      code  = EVT_IRQ;

      if (since_edge != cmax) since_edge = since_edge + 1'b1;
      if (confirm_pending && confirm_timer != '0) confirm_timer = confirm_timer - 1'b1;

      if (restart) begin
        accepted_level = pin;
        raw_last       = pin;
        since_edge     = '0;
      end else begin
        toggled  = (pin != raw_last) && detect_en;
        raw_last = pin;
        if (toggled) begin
          spacing         = since_edge;
          since_edge      = '0;
          confirm_pending = 1'b0;
          confirm_timer   = '0;
          // closer than the IRQ spacing: glitch, level kept
          if (spacing >= irq_min) begin
            if (!accepted_level && pin && spacing < level_min) begin
              if (dp) begin
                fired = 1'b1;
                code  = EVT_IRQ;
              end
            end else if (spacing >= level_min) begin
              confirm_pending = 1'b1;
              confirm_timer   = (level_min > cmax) ? cmax : CountWidth'(level_min);
            end
            accepted_level = pin;
          end
        end
      end

      if (confirm_pending && confirm_timer == '0) begin
        confirm_pending = 1'b0;
        if (pin == accepted_level && dp && !fired) begin
          fired = 1'b1;
          code  = pin ? EVT_HIGH : EVT_LOW;
        end
      end

      if (fired) event_q.push_back(code);
    endfunction

    function void check_result(logic [1:0] got);
      hpd_event_e want;
      if (event_q.size() == 0) begin
        $error("hpd_event: expected none, got %0d", got);
        errors++;
      end else begin
        want = event_q.pop_front();
        if (got !== want) begin
          $error("hpd_event: expected %0d, got %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return event_q.size();
    endfunction

    function void flag_leftovers();
      foreach (event_q[i]) begin
        $error("hpd_event: expected %0d, got none", event_q[i]);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic                    hpd_sample_i = 1'b0;
  logic                    dp_mode_i    = 1'b0;
  logic                    restart_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [1:0]              hpd_event_o;
  logic                    cfg_valid_i  = 1'b0;
  logic                    cfg_ready_o;
  cfg_idx_t                cfg_index_i  = CFG_DETECT_ENABLE;
  logic [CfgDataWidth-1:0] cfg_data_i   = '0;

  // random stalls on both channels while set
  bit idle_on = 1'b1;

  hpd_scoreboard sb = new();

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  hotplug_detect_classifier #(
    .COUNT_WIDTH(CountWidth)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .hpd_sample_i(hpd_sample_i),
    .dp_mode_i   (dp_mode_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hpd_event_o (hpd_event_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Event side: check what was taken at this edge, then pick next ready.
  // Non-clock DUT inputs are driven nonblocking, so values read here are pre-edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(hpd_event_o);
      out_ready_i <= idle_on ? ($urandom_range(0, 99) >= IdlePercent) : 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------

  // One pin item; may open with a short gap. Valid stays up when no gap is
  // taken, so back-to-back items see a single assignment per edge.
  task automatic send_tick(logic pin, logic dp, logic restart);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hpd_sample_i <= pin;
    dp_mode_i    <= dp;
    restart_i    <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(pin, dp, restart);
  endtask

  task automatic hold(logic pin, int unsigned n, logic dp);
    repeat (n) send_tick(pin, dp, 1'b0);
  endtask

  // Stop sending and let every expected event drain; the extra cycles cover
  // an item still in flight that produces nothing.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; only called while settled.
  task automatic configure(logic en, logic [CfgDataWidth-1:0] irq,
                           logic [CfgDataWidth-1:0] lvl);
    cfg_idx_t                idx [3];
    logic [CfgDataWidth-1:0] val [3];
    idx[0] = CFG_DETECT_ENABLE; val[0] = {{(CfgDataWidth-1){1'b0}}, en};
    idx[1] = CFG_IRQ_MIN;       val[1] = irq;
    idx[2] = CFG_LEVEL_MIN;     val[2] = lvl;
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Pulse trains: each run flips the pin and holds it for a span drawn from
  // glitch, IRQ-window or level-change range of the current registers.
  // Sprinkled noise: single-tick pin flips, dp_mode drops, restarts.
  task automatic run_pulses(int unsigned n_ticks);
    int unsigned sent;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int unsigned irq;
    int unsigned lvl;
    logic        level;
    logic        pin;
    logic        dp;
    logic        rs;
    sent  = 0;
    irq   = sb.irq_min;
    lvl   = sb.level_min;
    level = hpd_sample_i;
    while (sent < n_ticks) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        lo = 1;
        hi = (irq > 1) ? irq - 1 : 1;
      end else if (pick < 5) begin
        lo = (irq > 0) ? irq : 1;
        hi = (lvl > lo) ? lvl : lo;
      end else begin
        lo = (lvl > 0) ? lvl : 1;
        hi = 2 * lvl + 3;
      end
      span  = $urandom_range(hi, lo);
      level = ~level;
      repeat (span) begin
        pin = ($urandom_range(0, 29) == 0) ? ~level : level;
        dp  = ($urandom_range(0, 9) != 0);
        rs  = ($urandom_range(0, 49) == 0);
        send_tick(pin, dp, rs);
        sent++;
      end
      // now and then hold the sender until all events are back
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // detection off after reset: pin toggles are ignored
    hold(1'b1, 2, 1'b1);
    hold(1'b0, 1, 1'b1);
    settle();

    // directed walk with tight spacings: glitch below 2, IRQ window 2..3,
    // level change from 4, confirm after 4 ticks
    configure(1'b1, 16'd2, 16'd4);
    send_tick(1'b0, 1'b1, 1'b1);     // restart at low
    hold(1'b0, 4, 1'b1);
    hold(1'b1, 5, 1'b1);             // level change, confirmed high
    hold(1'b0, 3, 1'b1);             // level change, confirm cancelled by next edge
    hold(1'b1, 1, 1'b1);             // rise inside window: IRQ pulse
    hold(1'b0, 1, 1'b1);             // glitch
    hold(1'b1, 2, 1'b0);             // glitch, dp_mode off
    hold(1'b0, 4, 1'b0);             // fall inside window: level only
    hold(1'b1, 3, 1'b1);             // confirm starts ...
    send_tick(1'b0, 1'b1, 1'b1);     // ... restart keeps it running
    hold(1'b0, 4, 1'b1);             // expires against reloaded level: low
    settle();

    // random pulse trains over several register settings
    configure(1'b1, 16'($urandom_range(0, 4)), 16'($urandom_range(4, 16)));
    run_pulses(300);
    settle();

    // level spacing may fall below the IRQ spacing here
    configure(1'b1, 16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
    run_pulses(300);
    settle();

    // stretch without any stalls
    idle_on = 1'b0;
    configure(1'b1, 16'd2, 16'd10);
    run_pulses(300);
    settle();
    idle_on = 1'b1;

    // detection off again; a confirm left over may still expire
    configure(1'b0, 16'd3, 16'd8);
    run_pulses(150);
    settle();

    // zero spacings: every edge is a level change confirmed in the same tick
    configure(1'b1, 16'd0, 16'd0);
    run_pulses(150);
    settle();

    configure(1'b1, 16'($urandom_range(1, 6)), 16'($urandom_range(6, 20)));
    run_pulses(300);
    settle();

    // full-scale spacings: every edge falls below the IRQ spacing, so each
    // one is a glitch that reports nothing
    configure(1'b1, 16'hFFFF, 16'hFFFF);
    send_tick(1'b0, 1'b1, 1'b1);
    hold(1'b0, 20, 1'b1);
    hold(1'b1, 20, 1'b1);
    hold(1'b0, 20, 1'b1);

    settle();
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== hotplug_detect_classifier.f =====
rtl/hdc_pkg.sv
rtl/hdc_cfg.sv
rtl/hdc_core.sv
rtl/hotplug_detect_classifier.sv
dv/tb_hotplug_detect_classifier.sv
